// ===== sv/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg: shared types, constants and float helpers
// Single-precision multiply, add, normalize and round steps. Each step is
// one pipeline stage of the affine point transform.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int NumRows   = 3;
  localparam int NumRegs   = 6;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int NumStages = 12;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // Identity matrix, zero translation
  localparam logic [CfgDataW-1:0] CfgReset [NumRegs] = '{
    64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000,
    64'h0, 64'h0, 64'h0000_0000_3F80_0000
  };

  // Unrounded value: mag * 2^(exp - 127 - 47), or a finished special word
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] exp;
    logic [47:0]        mag;
  } raw_t;

  typedef struct packed {
    logic [NumRows-1:0][31:0] coord;
    logic                     go;
  } pass_t;

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic raw_t fp_mul(logic [31:0] a, logic [31:0] b);
    raw_t       r;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = !(|a[30:0]);
    b_zero = !(|b[30:0]);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    r.sign = a[31] ^ b[31];
    r.spec = a_nan | b_nan | a_inf | b_inf;
    r.spec_val = (a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero)) ?
                 CanonNan : {r.sign, 8'hFF, 23'h0};
    r.exp = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
    r.mag = {24'b0, ma} * {24'b0, mb};
    return r;
  endfunction

  function automatic raw_t fp_add(logic [31:0] a, logic [31:0] b);
    raw_t        r;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] big, sml;
    logic [7:0]  eb, es, d;
    logic [47:0] mb, ms, al, mask, sum;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    swap = b[30:0] > a[30:0];
    big  = swap ? b : a;
    sml  = swap ? a : b;
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eb - es;
    mb = {1'b0, |big[30:23], big[22:0], 23'b0};
    ms = {1'b0, |sml[30:23], sml[22:0], 23'b0};
    al = ms >> d;
    mask = (48'd1 << d) - 48'd1;
    al[0] = al[0] | (|(ms & mask));
    sum = (a[31] ^ b[31]) ? (mb - al) : (mb + al);
    r.spec = a_nan | b_nan | a_inf | b_inf;
    r.spec_val = (a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]))) ?
                 CanonNan : {(a_inf ? a[31] : b[31]), 8'hFF, 23'h0};
    r.sign = (sum == 48'd0) ? (a[31] & b[31]) : big[31];
    r.exp  = $signed({3'b0, eb}) + 11'sd1;
    r.mag  = sum;
    return r;
  endfunction

  function automatic raw_t fp_norm(raw_t x);
    raw_t       r;
    logic [5:0] lz;
    r  = x;
    lz = lzc48(x.mag);
    if (!x.spec && (x.mag != 48'd0)) begin
      r.mag = x.mag << lz;
      r.exp = x.exp - $signed({5'b0, lz});
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_round(raw_t x);
    logic signed [11:0] shw;
    logic [5:0]  sh;
    logic [47:0] shd, mask;
    logic [23:0] m;
    logic        rb, st, inc;
    logic [7:0]  ef;
    logic [30:0] pk;
    logic [31:0] res;
    shw = 12'sd1 - $signed({x.exp[10], x.exp});
    sh  = (x.exp >= 11'sd1) ? 6'd0 : ((shw > 12'sd48) ? 6'd48 : shw[5:0]);
    shd  = x.mag >> sh;
    mask = (48'd1 << sh) - 48'd1;
    m   = shd[47:24];
    rb  = shd[23];
    st  = (|shd[22:0]) | (|(x.mag & mask));
    inc = rb & (st | m[0]);
    ef  = (x.exp >= 11'sd1) ? x.exp[7:0] : 8'd0;
    pk  = {ef, m[22:0]} + {30'b0, inc};
    if (x.spec) begin
      res = x.spec_val;
    end else if (x.mag == 48'd0) begin
      res = {x.sign, 31'b0};
    end else if (x.exp >= 11'sd255) begin
      res = {x.sign, 8'hFF, 23'h0};
    end else begin
      res = {x.sign, pk};
    end
    return res;
  endfunction

endpackage

// ===== sv/apt_if.sv =====
// ----------------------------------------------------------------------------
// apt_if: point and result channels
// Valid/ready channels that carry one point or one transformed point.
// ----------------------------------------------------------------------------
interface apt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;
  logic        three_wide;
  modport source (output valid, x_in, y_in, z_in, three_wide, input ready);
  modport sink   (input valid, x_in, y_in, z_in, three_wide, output ready);
endinterface

interface apt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic [31:0] z_out;
  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

// ===== sv/affine_point_transform.sv =====
// ----------------------------------------------------------------------------
// affine_point_transform: 3-D point times the upper 3x4 of a 4x4 matrix
// Per row: ((m0*x + m1*y) + m2*z) + m3, every product and sum rounded to
// single precision, nearest even. Points flagged not three-wide pass as is.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  point     in   valid/ready    x_in, y_in, z_in, three_wide
//  result    out  valid/ready    x_out, y_out, z_out
//  cfg       in   cfg_we         cfg_index, cfg_data (six 64-bit registers)
//
//  One item per cycle while result accepts or a bubble remains; four float
//  steps of three stages each (align/multiply, normalize, round).
//  Reset clears all stage valid bits and loads the identity matrix.
//  A stall at result holds only the stages that are full; empty stages
//  keep filling, so point.ready stays high while any bubble remains.
// ----------------------------------------------------------------------------
module affine_point_transform (
  input  logic                         clk,
  input  logic                         rst,
  apt_in_if.sink                       point,
  apt_out_if.source                    result,
  input  logic                         cfg_we,
  input  logic [apt_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [apt_pkg::CfgDataW-1:0] cfg_data
);
  import apt_pkg::*;

  logic [CfgDataW-1:0]  cfg_reg [NumRegs];
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] adv;
  pass_t                pass_q [NumStages];
  logic [31:0]          res [NumRows];

  // Matrix registers; writes past the last register drop
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) cfg_reg[i] <= CfgReset[i];
    end else if (cfg_we && (cfg_index < CfgIdxW'(NumRegs))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[NumStages-1] = !vld[NumStages-1] || result.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign point.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= point.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Raw point and mode flag travel beside the arithmetic
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pass_q[0].coord <= {point.z_in, point.y_in, point.x_in};
      pass_q[0].go    <= point.three_wide;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) pass_q[k] <= pass_q[k-1];
    end
  end

  for (genvar r = 0; r < NumRows; r++) begin : g_row
    logic [31:0] m0, m1, m2, m3;
    raw_t        s1_a, s1_b, s1_c, s2_a, s2_b, s2_c;
    logic [31:0] s3_a, s3_b, s3_c;
    raw_t        s4_sum, s5_sum;
    logic [31:0] s4_c, s5_c, s6_s, s6_c;
    raw_t        s7_sum, s8_sum;
    logic [31:0] s9_s;
    raw_t        s10_sum, s11_sum;
    logic [31:0] res_q;

    assign m0 = cfg_reg[2*r][31:0];
    assign m1 = cfg_reg[2*r][63:32];
    assign m2 = cfg_reg[2*r+1][31:0];
    assign m3 = cfg_reg[2*r+1][63:32];

    always_ff @(posedge clk) begin
      // products
      if (adv[0]) begin
        s1_a <= fp_mul(m0, point.x_in);
        s1_b <= fp_mul(m1, point.y_in);
        s1_c <= fp_mul(m2, point.z_in);
      end
      if (adv[1]) begin
        s2_a <= fp_norm(s1_a);
        s2_b <= fp_norm(s1_b);
        s2_c <= fp_norm(s1_c);
      end
      if (adv[2]) begin
        s3_a <= fp_round(s2_a);
        s3_b <= fp_round(s2_b);
        s3_c <= fp_round(s2_c);
      end
      // first sum, third product waits alongside
      if (adv[3]) begin
        s4_sum <= fp_add(s3_a, s3_b);
        s4_c   <= s3_c;
      end
      if (adv[4]) begin
        s5_sum <= fp_norm(s4_sum);
        s5_c   <= s4_c;
      end
      if (adv[5]) begin
        s6_s <= fp_round(s5_sum);
        s6_c <= s5_c;
      end
      // second sum
      if (adv[6]) s7_sum <= fp_add(s6_s, s6_c);
      if (adv[7]) s8_sum <= fp_norm(s7_sum);
      if (adv[8]) s9_s   <= fp_round(s8_sum);
      // translation
      if (adv[9])  s10_sum <= fp_add(s9_s, m3);
      if (adv[10]) s11_sum <= fp_norm(s10_sum);
      if (adv[11]) begin
        res_q <= pass_q[10].go ? fp_round(s11_sum) : pass_q[10].coord[r];
      end
    end

    assign res[r] = res_q;
  end

  assign result.valid = vld[NumStages-1];
  assign result.x_out = res[0];
  assign result.y_out = res[1];
  assign result.z_out = res[2];

  // An empty output stage must let a new item in
  a_ready_on_bubble: assert property (@(posedge clk) disable iff (rst)
    !vld[NumStages-1] |-> point.ready)
    else $error("point stalled with empty output stage");

  // An item taken with nothing delivered grows the in-flight count by one
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready && !(result.valid && result.ready)) |=>
    ($countones(vld) == $past($countones(vld)) + 1))
    else $error("item lost or duplicated in pipeline");

  // Transformed NaNs leave x_out in canonical form
  a_canon_nan: assert property (@(posedge clk) disable iff (rst)
    (result.valid && pass_q[NumStages-1].go && (&result.x_out[30:23]) &&
     (|result.x_out[22:0])) |-> (result.x_out == CanonNan))
    else $error("non-canonical NaN on x_out");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: affine point transform check
// Streams 3-D points through the block under several matrix settings and
// checks each transformed point bit for bit against a local predictor of
// single-precision multiply and add with round to nearest even.
// ----------------------------------------------------------------------------
module testbench;
  import apt_pkg::*;

  localparam logic [31:0] QuietNan   = 32'h7FC0_0000;
  localparam int          WatchLimit = 5000;
  localparam int          DrainWait  = NumStages + 8;
  localparam int          RandPhases = 8;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        three_wide;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } coord_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  apt_in_if  pin ();
  apt_out_if pout ();

  affine_point_transform DUT (
    .clk       (clk),
    .rst       (rst),
    .point     (pin),
    .result    (pout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the matrix registers
  logic [63:0] matrix [NumRegs];

  point_t pending_points [$];
  coord_t expected_results [$];

  int  fail_count;
  int  points_sent;
  int  results_checked;
  int  send_gap;
  int  recv_gap;
  int  idle_cycles;
  bit  no_idle;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Float predictor
  // --------------------------------------------------------------------------

  // Round sign * m * 2^e to single precision, nearest even, subnormals kept.
  function automatic logic [31:0] round_pack(logic sgn, int e, logic [127:0] m);
    int           p;
    int           q;
    int           sh;
    int           ebias;
    logic [127:0] s;
    logic         rb;
    logic         st;
    if (m == 0) return {sgn, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) begin
      if (m[i]) p = i;
    end
    // quantum of the result: 23 bits below the leading one, never below 2^-149
    q = p + e - 23;
    if (q < -149) q = -149;
    sh = q - e;
    if (sh > 0) begin
      s  = m >> sh;
      rb = (sh - 1 < 128) ? m[sh-1] : 1'b0;
      st = |(m & ((128'd1 << (sh - 1)) - 128'd1));
      if (rb && (st || s[0])) s = s + 128'd1;
    end else begin
      s = m << (-sh);
    end
    // carry out of rounding: renormalize, exact since s is even then
    if (s[24]) begin
      s = s >> 1;
      q = q + 1;
    end
    if (!s[23]) return {sgn, 8'd0, s[22:0]};
    ebias = q + 150;
    if (ebias >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, ebias[7:0], s[22:0]};
  endfunction

  function automatic logic is_nan(logic [31:0] v);
    return (&v[30:23]) && (|v[22:0]);
  endfunction

  function automatic logic is_inf(logic [31:0] v);
    return (&v[30:23]) && !(|v[22:0]);
  endfunction

  // Significand as an integer; the value is sig * 2^(scale)
  function automatic logic [127:0] sig_of(logic [31:0] v);
    return (v[30:23] != 8'd0) ? {104'd0, 1'b1, v[22:0]} : {105'd0, v[22:0]};
  endfunction

  function automatic int scale_of(logic [31:0] v);
    return ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QuietNan;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QuietNan;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'd0};
    return round_pack(sgn, scale_of(a) + scale_of(b), sig_of(a) * sig_of(b));
  endfunction

  // Shift right by d below 60 guard bits, folding lost bits into the lsb
  function automatic logic [127:0] align_sig(logic [127:0] m, int d);
    logic [127:0] w;
    logic [127:0] t;
    w = m << 60;
    t = w >> d;
    if ((t << d) != w) t[0] = 1'b1;
    return t;
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    int           ea;
    int           eb;
    int           ex;
    logic [127:0] aa;
    logic [127:0] bb;
    logic [127:0] sum;
    logic         sgn;
    if (is_nan(a) || is_nan(b)) return QuietNan;
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QuietNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    ea = scale_of(a);
    eb = scale_of(b);
    ex = (ea > eb) ? ea : eb;
    aa = align_sig(sig_of(a), ex - ea);
    bb = align_sig(sig_of(b), ex - eb);
    if (a[31] == b[31]) begin
      sum = aa + bb;
      sgn = a[31];
    end else if (aa >= bb) begin
      sum = aa - bb;
      sgn = a[31];
    end else begin
      sum = bb - aa;
      sgn = b[31];
    end
    // exact cancellation gives +0 under round to nearest
    if (sum == 0) return 32'd0;
    return round_pack(sgn, ex - 60, sum);
  endfunction

  function automatic logic [31:0] row_value(int r, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z);
    logic [63:0] c01;
    logic [63:0] c23;
    logic [31:0] s;
    c01 = matrix[2*r];
    c23 = matrix[2*r+1];
    s = fadd(fmul(c01[31:0], x), fmul(c01[63:32], y));
    s = fadd(s, fmul(c23[31:0], z));
    s = fadd(s, c23[63:32]);
    if (is_nan(s)) s = QuietNan;
    return s;
  endfunction

  function automatic coord_t transform_point(point_t p);
    coord_t c;
    if (!p.three_wide) begin
      c.x = p.x;
      c.y = p.y;
      c.z = p.z;
    end else begin
      c.x = row_value(0, p.x, p.y, p.z);
      c.y = row_value(1, p.x, p.y, p.z);
      c.z = row_value(2, p.x, p.y, p.z);
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mix of special values, values near one (cancellation) and raw patterns
  function automatic logic [31:0] rand_float();
    int          pick;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    v = $urandom;
    if (pick < 15) begin
      case ($urandom_range(0, 7))
        0: v = {v[31], 31'd0};
        1: v = {v[31], 8'hFF, 23'd0};
        2: v = {v[31], 8'hFF, 1'b1, v[21:0]};
        3: v = {v[31], 8'hFF, 22'd0, 1'b1};
        4: v = {v[31], 8'd0, v[22:0]};
        5: v = {v[31], 8'hFE, 23'h7FFFFF};
        6: v = {v[31], 8'd1, v[22:0]};
        default: v = {v[31], 8'd0, 22'd0, 1'b1};
      endcase
    end else if (pick < 75) begin
      v[30:23] = 8'($urandom_range(120, 134));
    end
    return v;
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_float(), rand_float()};
  endfunction

  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic tw);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.three_wide = tw;
    pending_points.push_back(p);
  endtask

  task automatic add_random_points(int n);
    for (int i = 0; i < n; i++) begin
      add_point(rand_float(), rand_float(), rand_float(), $urandom_range(0, 99) < 85);
    end
  endtask

  // Write all six registers plus the two unused indexes, which must be ignored
  task automatic load_matrix(logic [63:0] m [NumRegs]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      if (i < NumRegs) begin
        cfg_data  <= m[i];
        matrix[i] = m[i];
      end else begin
        cfg_data <= {$urandom, $urandom};
      end
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every point has gone in and every result has come out;
  // sample between edges so the driver's updates have settled
  task automatic drain();
    while (pending_points.size() != 0 || pin.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next point, hold it until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pin.valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (pin.valid && pin.ready) begin
        point_t acc;
        acc.x = pin.x_in;
        acc.y = pin.y_in;
        acc.z = pin.z_in;
        acc.three_wide = pin.three_wide;
        expected_results.push_back(transform_point(acc));
        points_sent <= points_sent + 1;
      end
      if (!pin.valid || pin.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          pin.valid <= 1'b0;
        end else if (pending_points.size() != 0) begin
          point_t nxt;
          nxt = pending_points.pop_front();
          pin.valid      <= 1'b1;
          pin.x_in       <= nxt.x;
          pin.y_in       <= nxt.y;
          pin.z_in       <= nxt.z;
          pin.three_wide <= nxt.three_wide;
          send_gap       <= rand_gap();
        end else begin
          pin.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall ready at random, compare each result with the oldest one due
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      if (pout.valid && pout.ready) begin
        coord_t want;
        results_checked <= results_checked + 1;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %h %h %h",
                 pout.x_out, pout.y_out, pout.z_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (pout.x_out !== want.x) begin
            $error("x_out expected %h actual %h", want.x, pout.x_out);
            fail_count++;
          end
          if (pout.y_out !== want.y) begin
            $error("y_out expected %h actual %h", want.y, pout.y_out);
            fail_count++;
          end
          if (pout.z_out !== want.z) begin
            $error("z_out expected %h actual %h", want.z, pout.z_out);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        pout.ready <= 1'b0;
      end else begin
        pout.ready <= 1'b1;
        recv_gap   <= rand_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((pin.valid && pin.ready) || (pout.valid && pout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] m [NumRegs];
    int          kind;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pin.valid   = 1'b0;
    pin.x_in    = '0;
    pin.y_in    = '0;
    pin.z_in    = '0;
    pin.three_wide = 1'b0;
    pout.ready  = 1'b0;
    fail_count  = 0;
    points_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    send_gap    = 0;
    recv_gap    = 0;
    no_idle     = 1'b0;
    for (int i = 0; i < NumRegs; i++) matrix[i] = CfgReset[i];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed points under the reset identity matrix
    add_point(32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 1'b1);
    add_point(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
    add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    // pass-through keeps NaN payloads
    add_point(32'h7FA1_2345, 32'hFF80_0001, 32'hFFFF_FFFF, 1'b0);
    add_point(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 1'b1);
    // subnormals are kept
    add_point(32'h0000_0001, 32'h807F_FFFF, 32'h0040_0000, 1'b1);
    add_point(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000, 1'b1);
    drain();

    // Overflow, invalid operations and subnormal products
    m[0] = {32'h7F7F_FFFF, 32'h7F7F_FFFF};
    m[1] = {32'h3F80_0000, 32'h0000_0001};
    m[2] = {32'h7F80_0000, 32'h0000_0000};
    m[3] = {32'hFF80_0000, 32'h3F00_0000};
    m[4] = {32'h3F80_0000, 32'hBF80_0000};
    m[5] = {32'h0000_0000, 32'h0080_0000};
    load_matrix(m);
    add_point(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h3F80_0000, 1'b1);
    add_point(32'h0000_0000, 32'h3F80_0000, 32'h0000_0001, 1'b1);
    add_point(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
    add_point(32'h3F80_0001, 32'h3F80_0000, 32'h8000_0000, 1'b1);
    add_point(32'h8000_0000, 32'h7FC0_0001, 32'h0000_0000, 1'b1);
    add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    add_point(32'h3400_0000, 32'h3F80_0000, 32'hBF80_0000, 1'b1);
    add_point(32'hFF7F_FFFF, 32'h0000_0000, 32'h7F80_0000, 1'b0);
    drain();

    // All-ones registers: every coefficient is a NaN
    for (int i = 0; i < NumRegs; i++) m[i] = '1;
    load_matrix(m);
    add_random_points(6);
    drain();

    // Random phases, including all-zero and huge matrices
    for (int ph = 0; ph < RandPhases; ph++) begin
      kind = $urandom_range(0, 3);
      for (int i = 0; i < NumRegs; i++) begin
        case (kind)
          0: m[i] = '0;
          1: m[i] = {32'h7F7F_FFFF ^ ($urandom & 32'h8000_000F), 32'h7F00_0000 | $urandom};
          default: m[i] = rand_pair();
        endcase
      end
      if (ph == 0) for (int i = 0; i < NumRegs; i++) m[i] = '0;
      no_idle = ($urandom_range(0, 3) == 0);
      load_matrix(m);
      add_random_points(60);
      drain();
    end

    // Back to the identity to close
    no_idle = 1'b0;
    for (int i = 0; i < NumRegs; i++) m[i] = CfgReset[i];
    load_matrix(m);
    add_random_points(20);
    drain();

    $display("sent %0d points and checked %0d results over %0d matrix settings",
             points_sent, results_checked, RandPhases + 4);
    $display("covered pass-through, NaN, infinity, overflow and subnormal cases");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/apt_pkg.sv
sv/apt_if.sv
sv/affine_point_transform.sv
verif/testbench.sv
